@@ rtl/core/tc8_pkg.sv @@
// ============================================================================
// tc8_pkg
// Shared types, codes and defaults for the 8-bit timer/counter core.
// ============================================================================
package tc8_pkg;

	localparam int COUNT_WIDTH_DEF    = 8;
	localparam int PRESCALE_WIDTH_DEF = 10;

	// Transaction kinds
	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_READ  = 2'd2
	} action_t;

	// Register map
	localparam logic [2:0] REG_CONTROL = 3'd0;
	localparam logic [2:0] REG_COUNT   = 3'd1;
	localparam logic [2:0] REG_COMPARE = 3'd2;
	localparam logic [2:0] REG_IRQ_EN  = 3'd3;
	localparam logic [2:0] REG_FLAGS   = 3'd4;

	// Clock select codes
	localparam logic [2:0] CS_STOP    = 3'd0;
	localparam logic [2:0] CS_DIV1    = 3'd1;
	localparam logic [2:0] CS_DIV8    = 3'd2;
	localparam logic [2:0] CS_DIV64   = 3'd3;
	localparam logic [2:0] CS_DIV256  = 3'd4;
	localparam logic [2:0] CS_DIV1024 = 3'd5;

	// Prescaler tap widths (low bits that must be zero)
	localparam int DIV8_BITS    = 3;
	localparam int DIV64_BITS   = 6;
	localparam int DIV256_BITS  = 8;
	localparam int DIV1024_BITS = 10;

	// Control register bit positions
	localparam int CTRL_WGM0_BIT = 6;
	localparam int CTRL_COM1_BIT = 5;
	localparam int CTRL_COM0_BIT = 4;
	localparam int CTRL_WGM1_BIT = 3;
	localparam logic [7:0] CTRL_WRITE_MASK = 8'h7F;

	// Interrupt enable and flag bit positions
	localparam int IRQ_OVF_BIT = 0;
	localparam int IRQ_CMP_BIT = 1;

	typedef struct packed {
		logic [1:0] action;
		logic [2:0] reg_select;
		logic [7:0] write_data;
	} tc8_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       overflow_irq;
		logic       compare_irq;
		logic       pwm_out;
	} tc8_result_t;

endpackage

@@ rtl/core/tc8_prescaler.sv @@
// ============================================================================
// tc8_prescaler
// Free-running prescale counter and timer clock enable decode.
// ============================================================================
module tc8_prescaler #(
	parameter int PRESCALE_WIDTH = tc8_pkg::PRESCALE_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [2:0] clock_select,
	output logic       timer_due
);

	logic [PRESCALE_WIDTH-1:0] prescale_q;
	logic [PRESCALE_WIDTH-1:0] prescale_next;

	assign prescale_next = prescale_q + {{(PRESCALE_WIDTH-1){1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
		end else if (advance) begin
			prescale_q <= prescale_next;
		end
	end

	// Decode against the advanced count
	always_comb begin
		case (clock_select)
			tc8_pkg::CS_DIV1:    timer_due = 1'b1;
			tc8_pkg::CS_DIV8:    timer_due = (prescale_next[tc8_pkg::DIV8_BITS-1:0] == '0);
			tc8_pkg::CS_DIV64:   timer_due = (prescale_next[tc8_pkg::DIV64_BITS-1:0] == '0);
			tc8_pkg::CS_DIV256:  timer_due = (prescale_next[tc8_pkg::DIV256_BITS-1:0] == '0);
			tc8_pkg::CS_DIV1024: timer_due = (prescale_next[tc8_pkg::DIV1024_BITS-1:0] == '0);
			default:             timer_due = 1'b0;
		endcase
	end

endmodule

@@ rtl/core/tc8_timer.sv @@
// ============================================================================
// tc8_timer
// Register file, counter update and compare/PWM pin logic.
// ============================================================================
module tc8_timer #(
	parameter int COUNT_WIDTH = tc8_pkg::COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  tc8_pkg::tc8_item_t   item,
	input  logic                 timer_due,
	output logic [2:0]           clock_select,
	output tc8_pkg::tc8_result_t result
);

	logic [6:0]             control_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] compare_q;
	logic [1:0]             irq_en_q;
	logic [1:0]             flags_q;
	logic                   pin_q;

	logic [6:0]             control_d;
	logic [COUNT_WIDTH-1:0] count_d;
	logic [COUNT_WIDTH-1:0] compare_d;
	logic [1:0]             irq_en_d;
	logic [1:0]             flags_d;
	logic                   pin_d;
	logic [7:0]             read_d;

	logic clear_on_match;
	logic pwm_mode;
	logic pin_driven;
	logic invert;
	logic match;
	logic [COUNT_WIDTH-1:0] count_inc;

	assign clock_select   = control_q[2:0];
	assign clear_on_match = control_q[tc8_pkg::CTRL_WGM1_BIT] & ~control_q[tc8_pkg::CTRL_WGM0_BIT];
	assign pwm_mode       = control_q[tc8_pkg::CTRL_WGM1_BIT] & control_q[tc8_pkg::CTRL_WGM0_BIT];
	assign pin_driven     = pwm_mode & control_q[tc8_pkg::CTRL_COM1_BIT];
	assign invert         = control_q[tc8_pkg::CTRL_COM0_BIT];
	assign match          = (count_q == compare_q);
	assign count_inc      = count_q + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

	always_comb begin
		control_d = control_q;
		count_d   = count_q;
		compare_d = compare_q;
		irq_en_d  = irq_en_q;
		flags_d   = flags_q;
		pin_d     = pin_q;
		read_d    = '0;
		case (item.action)
			tc8_pkg::ACT_TICK: begin
				if (timer_due) begin
					if (match) begin
						flags_d[tc8_pkg::IRQ_CMP_BIT] = 1'b1;
					end
					if (clear_on_match && match) begin
						count_d = '0;
					end else if (count_q == {COUNT_WIDTH{1'b1}}) begin
						count_d = '0;
						flags_d[tc8_pkg::IRQ_OVF_BIT] = 1'b1;
					end else begin
						count_d = count_inc;
					end
					// Set at bottom, clear on match (polarity swapped when inverting)
					if (pin_driven) begin
						if (count_d == '0) begin
							pin_d = ~invert;
						end else if (match) begin
							pin_d = invert;
						end
					end
				end
			end
			tc8_pkg::ACT_WRITE: begin
				case (item.reg_select)
					tc8_pkg::REG_CONTROL: control_d = item.write_data[6:0];
					tc8_pkg::REG_COUNT:   count_d   = COUNT_WIDTH'(item.write_data);
					tc8_pkg::REG_COMPARE: compare_d = COUNT_WIDTH'(item.write_data);
					tc8_pkg::REG_IRQ_EN:  irq_en_d  = item.write_data[1:0];
					tc8_pkg::REG_FLAGS:   flags_d   = flags_q & ~item.write_data[1:0];
					default:              ;
				endcase
			end
			tc8_pkg::ACT_READ: begin
				case (item.reg_select)
					tc8_pkg::REG_CONTROL: read_d = {1'b0, control_q} & tc8_pkg::CTRL_WRITE_MASK;
					tc8_pkg::REG_COUNT:   read_d = count_q[7:0];
					tc8_pkg::REG_COMPARE: read_d = compare_q[7:0];
					tc8_pkg::REG_IRQ_EN:  read_d = {6'd0, irq_en_q};
					tc8_pkg::REG_FLAGS:   read_d = {6'd0, flags_q};
					default:              read_d = '0;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= '0;
			count_q   <= '0;
			compare_q <= '0;
			irq_en_q  <= '0;
			flags_q   <= '0;
			pin_q     <= 1'b0;
		end else if (advance) begin
			control_q <= control_d;
			count_q   <= count_d;
			compare_q <= compare_d;
			irq_en_q  <= irq_en_d;
			flags_q   <= flags_d;
			pin_q     <= pin_d;
		end
	end

	// Result reflects the state after this transaction
	always_comb begin
		result.read_data    = read_d;
		result.overflow_irq = flags_d[tc8_pkg::IRQ_OVF_BIT] & irq_en_d[tc8_pkg::IRQ_OVF_BIT];
		result.compare_irq  = flags_d[tc8_pkg::IRQ_CMP_BIT] & irq_en_d[tc8_pkg::IRQ_CMP_BIT];
		result.pwm_out      = control_d[tc8_pkg::CTRL_WGM1_BIT] & control_d[tc8_pkg::CTRL_WGM0_BIT]
		                    & control_d[tc8_pkg::CTRL_COM1_BIT] & pin_d;
	end

endmodule

@@ rtl/core/timer_counter_8bit_ctc_pwm_core.sv @@
// ============================================================================
// timer_counter_8bit_ctc_pwm_core
// 8-bit timer/counter (normal, CTC, fast PWM) driven by a stream of
// transactions: a clock tick, a register write or a register read. Every
// transaction returns one result with the read byte (zero unless a read), the
// two interrupt lines and the PWM pin, all taken after the transaction has
// been applied. One transaction is accepted per cycle when the result side
// keeps up; the input register feeds the combinational counter update into
// the result register, and a stalled result side holds the input side once
// both registers are full.
// Registers: 0 control (bits 2..0 clock select, bits 6 and 3 mode, bits 5..4
// output mode, bit 7 reads zero), 1 counter, 2 compare, 3 interrupt enables,
// 4 flags (write one to clear). Bit 0 is overflow, bit 1 is compare.
// ============================================================================
module timer_counter_8bit_ctc_pwm_core #(
	parameter int COUNT_WIDTH    = tc8_pkg::COUNT_WIDTH_DEF,
	parameter int PRESCALE_WIDTH = tc8_pkg::PRESCALE_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [2:0] reg_select,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       overflow_irq,
	output logic       compare_irq,
	output logic       pwm_out
);

	tc8_pkg::tc8_item_t   item_s1;
	logic                 valid_s1;
	tc8_pkg::tc8_result_t result_s2;
	logic                 valid_s2;

	tc8_pkg::tc8_result_t result_d;
	logic                 advance;
	logic                 out_free;
	logic                 prescale_adv;
	logic                 timer_due;
	logic [2:0]           clock_select;

	// Result register frees when empty or being taken this cycle
	assign out_free = ~valid_s2 | out_ready;
	// Apply the held transaction to the timer state as it moves to the result
	assign advance  = valid_s1 & out_free;
	assign in_ready = ~valid_s1 | advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.action     <= action;
			item_s1.reg_select <= reg_select;
			item_s1.write_data <= write_data;
		end
	end

	// Prescaler advances on tick transactions only
	assign prescale_adv = advance && (item_s1.action == tc8_pkg::ACT_TICK);

	tc8_prescaler #(
		.PRESCALE_WIDTH (PRESCALE_WIDTH)
	) u_prescaler (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (prescale_adv),
		.clock_select (clock_select),
		.timer_due    (timer_due)
	);

	tc8_timer #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_timer (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.item         (item_s1),
		.timer_due    (timer_due),
		.clock_select (clock_select),
		.result       (result_d)
	);

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	assign out_valid    = valid_s2;
	assign read_data    = result_s2.read_data;
	assign overflow_irq = result_s2.overflow_irq;
	assign compare_irq  = result_s2.compare_irq;
	assign pwm_out      = result_s2.pwm_out;

endmodule
